// File: design/hws_pkg.sv
package hws_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ERR_W    = 33;
  localparam int GAIN_W   = 17;
  localparam int SLEN_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W   = 16;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_GAIN,
    CFG_TREND_GAIN,
    CFG_SEASON_GAIN,
    CFG_DAMPING_FACTOR,
    CFG_DAMPING_ENABLE,
    CFG_MULT_MODE,
    CFG_SEASON_LENGTH
  } hws_cfg_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } hws_op_e;

  typedef struct packed {
    logic    start;
    hws_op_e op;
  } hws_req_t;

  typedef struct packed {
    logic done;
    logic clamp;
  } hws_rsp_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIN
  } hws_ustate_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM,
    ST_LVL,
    ST_TRD,
    ST_SEA_RD,
    ST_SEA_DAT,
    ST_SEA_DIV,
    ST_P_RD,
    ST_P_DAT,
    ST_P_DT,
    ST_P_BASE,
    ST_P_PRED,
    ST_P_U,
    ST_P_V1,
    ST_P_V2,
    ST_P_W,
    ST_P_W1,
    ST_P_W2,
    ST_P_X1,
    ST_P_X2,
    ST_P_EMIT
  } hws_state_e;

endpackage

// File: design/hws_arith.sv
module hws_arith #(
  parameter int W  = 40,
  parameter int DW = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hws_pkg::hws_req_t    req_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  output hws_pkg::hws_rsp_t    rsp_o,
  output logic signed [W-1:0]  res_o
);

  localparam int NDIG = (DW + 3) / 4;
  localparam int MBW  = NDIG * 4;
  localparam int PW   = 2 * DW;
  localparam int MW   = PW + 1;
  localparam int NW   = DW + hws_pkg::FRAC_W;
  localparam int CW   = $clog2(NW + 1);
  localparam logic [MW-1:0] SMAX_M = MW'({(W-1){1'b1}});
  localparam logic [MW-1:0] SMIN_M = MW'({1'b1, {(W-1){1'b0}}});
  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

  hws_pkg::hws_ustate_e st_q, st_d;
  logic             neg_q, neg_d;
  logic             zero_q, zero_d;
  logic             az_q, az_d;
  logic [DW-1:0]    ma_q, ma_d;
  logic [MBW-1:0]   mb_q, mb_d;
  logic [NW-1:0]    num_q, num_d;
  logic [DW:0]      rem_q, rem_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             div_q, div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hws_pkg::U_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    zero_q <= zero_d;
    az_q <= az_d;
    ma_q <= ma_d;
    mb_q <= mb_d;
    num_q <= num_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    div_q <= div_d;
  end

  always_comb begin
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW+3:0] pp;
    logic [DW:0]   r2;
    logic [DW+1:0] rem2;
    logic [MW-1:0] m;
    logic          rnd;
    st_d = st_q;
    neg_d = neg_q;
    zero_d = zero_q;
    az_d = az_q;
    ma_d = ma_q;
    mb_d = mb_q;
    num_d = num_q;
    rem_d = rem_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    div_d = div_q;
    rsp_o = '0;
    res_o = '0;
    mag_a = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
    mag_b = b_i[DW-1] ? (~b_i + 1'b1) : b_i;
    pp = ma_q * mb_q[MBW-1 -: 4];
    r2 = {rem_q[DW-1:0], num_q[NW-1]};
    rem2 = {rem_q, 1'b0};
    rnd = rem2 >= (DW+2)'(mb_q[DW-1:0]);
    m = '0;
    case (st_q)
      hws_pkg::U_IDLE: begin
        if (req_i.start) begin
          neg_d = a_i[DW-1] ^ b_i[DW-1];
          ma_d = mag_a;
          mb_d = MBW'(mag_b);
          acc_d = '0;
          rem_d = '0;
          zero_d = 1'b0;
          az_d = (a_i == '0);
          div_d = (req_i.op == hws_pkg::OP_DIV);
          if (req_i.op == hws_pkg::OP_DIV) begin
            num_d = {mag_a, {hws_pkg::FRAC_W{1'b0}}};
            cnt_d = CW'(NW);
            if (b_i == '0) begin
              zero_d = 1'b1;
              neg_d = a_i[DW-1];
              st_d = hws_pkg::U_FIN;
            end else begin
              st_d = hws_pkg::U_DIV;
            end
          end else begin
            cnt_d = CW'(NDIG);
            st_d = hws_pkg::U_MUL;
          end
        end
      end
      hws_pkg::U_MUL: begin
        acc_d = (acc_q << 4) + PW'(pp);
        mb_d = mb_q << 4;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          st_d = hws_pkg::U_FIN;
        end
      end
      hws_pkg::U_DIV: begin
        if (r2 >= {1'b0, mb_q[DW-1:0]}) begin
          rem_d = r2 - {1'b0, mb_q[DW-1:0]};
          acc_d = {acc_q[PW-2:0], 1'b1};
        end else begin
          rem_d = r2;
          acc_d = {acc_q[PW-2:0], 1'b0};
        end
        num_d = num_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          st_d = hws_pkg::U_FIN;
        end
      end
      hws_pkg::U_FIN: begin
        rsp_o.done = 1'b1;
        st_d = hws_pkg::U_IDLE;
        if (zero_q) begin
          rsp_o.clamp = 1'b1;
          res_o = az_q ? '0 : (neg_q ? S_MIN : S_MAX);
        end else begin
          if (div_q) begin
            m = MW'(acc_q) + MW'(rnd);
          end else begin
            m = (MW'(acc_q) + MW'(17'h0_8000)) >> hws_pkg::FRAC_W;
          end
          if (neg_q) begin
            if (m > SMIN_M) begin
              rsp_o.clamp = 1'b1;
              res_o = S_MIN;
            end else begin
              res_o = ~m[W-1:0] + 1'b1;
            end
          end else begin
            if (m > SMAX_M) begin
              rsp_o.clamp = 1'b1;
              res_o = S_MAX;
            end else begin
              res_o = m[W-1:0];
            end
          end
        end
      end
      default: begin
        st_d = hws_pkg::U_IDLE;
      end
    endcase
  end

endmodule

// File: design/holt_winters_seasonal_predictor.sv
// Holt-Winters predictor with additive or multiplicative seasons and optional trend damping.
// The first 2*P samples are stored and give no result, except the last one, which sets up
// level, trend and season table and then emits P results for the replay of season two;
// every later sample gives one result. All multiplies and divides go through one shared
// iterative unit: a multiply works through one operand four bits at a time and a divide
// produces one quotient bit at a time for a DW+16 bit numerator, where DW is the larger of
// STATE_WIDTH and the warm-up sum width. Initialization sums the stored samples, does two
// divides, and sets each season entry in turn (with a divide each in multiplicative mode
// when the level is positive).
module holt_winters_seasonal_predictor #(
  parameter int MAX_SEASON  = 64,
  parameter int STATE_WIDTH = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hws_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hws_pkg::SAMPLE_W-1:0]  prediction_o,
  output logic signed [hws_pkg::ERR_W-1:0]     prediction_error_o,
  output logic                                 last_of_run_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_we_i,
  input  logic [hws_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hws_pkg::GAIN_W-1:0]           cfg_wdata_i
);

  localparam int W      = STATE_WIDTH;
  localparam int ACC_W  = hws_pkg::SAMPLE_W + 2 + $clog2(MAX_SEASON);
  localparam int DW     = (W > ACC_W) ? W : ACC_W;
  localparam int WA_W   = $clog2(2 * MAX_SEASON);
  localparam int TA_W   = $clog2(MAX_SEASON);
  localparam int PER_W  = $clog2(MAX_SEASON + 1);
  localparam int CNT_W  = PER_W + 1;
  localparam int LW     = (PER_W > hws_pkg::SLEN_W) ? PER_W : hws_pkg::SLEN_W;
  localparam logic signed [W-1:0] PMAX = W'(64'sh7FFF_FFFF);
  localparam logic signed [W-1:0] PMIN = W'(-64'sh8000_0000);
  localparam logic signed [W-1:0] ONE_S = W'(hws_pkg::GAIN_ONE);

  logic [hws_pkg::GAIN_W-1:0] lg_q, tg_q, sg_q, df_q;
  logic                       de_q, mm_q;
  logic [hws_pkg::SLEN_W-1:0] sl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= 17'd19661;
      tg_q <= 17'd6554;
      sg_q <= 17'd6554;
      df_q <= 17'd64225;
      de_q <= 1'b0;
      mm_q <= 1'b0;
      sl_q <= 7'd12;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hws_pkg::CFG_LEVEL_GAIN:     lg_q <= cfg_wdata_i;
        hws_pkg::CFG_TREND_GAIN:     tg_q <= cfg_wdata_i;
        hws_pkg::CFG_SEASON_GAIN:    sg_q <= cfg_wdata_i;
        hws_pkg::CFG_DAMPING_FACTOR: df_q <= cfg_wdata_i;
        hws_pkg::CFG_DAMPING_ENABLE: de_q <= cfg_wdata_i[0];
        hws_pkg::CFG_MULT_MODE:      mm_q <= cfg_wdata_i[0];
        hws_pkg::CFG_SEASON_LENGTH:  sl_q <= cfg_wdata_i[hws_pkg::SLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  function automatic logic [hws_pkg::GAIN_W-1:0] gclamp(input logic [hws_pkg::GAIN_W-1:0] g);
    return (g > hws_pkg::GAIN_ONE) ? hws_pkg::GAIN_ONE : g;
  endfunction

  function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b, input logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      return {1'b1, s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  logic [hws_pkg::GAIN_W-1:0] ga, gb, gg, gd;
  assign ga = gclamp(lg_q);
  assign gb = gclamp(tg_q);
  assign gg = gclamp(sg_q);
  assign gd = de_q ? gclamp(df_q) : hws_pkg::GAIN_ONE;

  logic [hws_pkg::SAMPLE_W-1:0] wb_mem [2*MAX_SEASON];
  logic [hws_pkg::SAMPLE_W-1:0] wb_rd_q, wb_wdata;
  logic [WA_W-1:0]              wb_waddr, wb_raddr;
  logic                         wb_we;
  logic [W-1:0]                 tb_mem [MAX_SEASON];
  logic [W-1:0]                 tb_rd_q, tb_wdata;
  logic [TA_W-1:0]              tb_waddr, tb_raddr;
  logic                         tb_we;

  always_ff @(posedge clk_i) begin
    if (wb_we) begin
      wb_mem[wb_waddr] <= wb_wdata;
    end
    wb_rd_q <= wb_mem[wb_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      tb_mem[tb_waddr] <= tb_wdata;
    end
    tb_rd_q <= tb_mem[tb_raddr];
  end

  hws_pkg::hws_req_t     req;
  hws_pkg::hws_rsp_t     rsp;
  logic signed [DW-1:0]  ua, ub;
  logic signed [W-1:0]   res;

  hws_arith #(
    .W  (W),
    .DW (DW)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (ua),
    .b_i    (ub),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  hws_pkg::hws_state_e state_q, state_d;
  logic                run_q, run_d;
  logic                clamp_q, clamp_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TA_W-1:0]     phase_q, phase_d;
  logic [PER_W-1:0]    per_q, per_d;
  logic [TA_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]    j_q, j_d;
  logic                rpend_q, rpend_d;
  logic                rhi_q, rhi_d;
  logic                replay_q, replay_d;
  logic                ov_q, ov_d;
  logic signed [W-1:0] lvl_q, lvl_d, trd_q, trd_d;
  logic signed [ACC_W-1:0] sum_q, sum_d, dif_q, dif_d;
  logic signed [W-1:0] y_q, y_d, s_q, s_d, dt_q, dt_d, base_q, base_d;
  logic signed [W-1:0] pred_q, pred_d, u_q, u_d, v_q, v_d, nl_q, nl_d;
  logic signed [hws_pkg::SAMPLE_W-1:0] opred_q, opred_d;
  logic signed [hws_pkg::ERR_W-1:0]    oerr_q, oerr_d;
  logic                olast_q, olast_d, osat_q, osat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hws_pkg::ST_IDLE;
      run_q <= 1'b0;
      clamp_q <= 1'b0;
      cnt_q <= '0;
      phase_q <= '0;
      per_q <= PER_W'(2);
      idx_q <= '0;
      j_q <= '0;
      rpend_q <= 1'b0;
      rhi_q <= 1'b0;
      replay_q <= 1'b0;
      ov_q <= 1'b0;
      lvl_q <= '0;
      trd_q <= '0;
    end else begin
      state_q <= state_d;
      run_q <= run_d;
      clamp_q <= clamp_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      per_q <= per_d;
      idx_q <= idx_d;
      j_q <= j_d;
      rpend_q <= rpend_d;
      rhi_q <= rhi_d;
      replay_q <= replay_d;
      ov_q <= ov_d;
      lvl_q <= lvl_d;
      trd_q <= trd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    dif_q <= dif_d;
    y_q <= y_d;
    s_q <= s_d;
    dt_q <= dt_d;
    base_q <= base_d;
    pred_q <= pred_d;
    u_q <= u_d;
    v_q <= v_d;
    nl_q <= nl_d;
    opred_q <= opred_d;
    oerr_q <= oerr_d;
    olast_q <= olast_d;
    osat_q <= osat_d;
  end

  logic [TA_W-1:0]  last_idx;
  logic [CNT_W-1:0] two_per;
  assign last_idx = TA_W'(per_q - PER_W'(1));
  assign two_per  = {per_q, 1'b0};

  always_comb begin
    logic [W:0]            r;
    logic [CNT_W-1:0]      ce;
    logic [PER_W-1:0]      pe;
    logic [LW-1:0]         sl;
    logic signed [W-1:0]   x;
    logic signed [ACC_W-1:0] xa;
    logic signed [W-1:0]   pcl;
    logic                  pc;
    logic [2*PER_W-1:0]    pp;
    state_d = state_q;
    run_d = run_q;
    clamp_d = clamp_q;
    cnt_d = cnt_q;
    phase_d = phase_q;
    per_d = per_q;
    idx_d = idx_q;
    j_d = j_q;
    rpend_d = rpend_q;
    rhi_d = rhi_q;
    replay_d = replay_q;
    lvl_d = lvl_q;
    trd_d = trd_q;
    sum_d = sum_q;
    dif_d = dif_q;
    y_d = y_q;
    s_d = s_q;
    dt_d = dt_q;
    base_d = base_q;
    pred_d = pred_q;
    u_d = u_q;
    v_d = v_q;
    nl_d = nl_q;
    opred_d = opred_q;
    oerr_d = oerr_q;
    olast_d = olast_q;
    osat_d = osat_q;
    ov_d = ov_q & out_stall_i;
    req = '0;
    ua = '0;
    ub = '0;
    wb_we = 1'b0;
    wb_waddr = '0;
    wb_wdata = sample_i;
    wb_raddr = '0;
    tb_we = 1'b0;
    tb_waddr = idx_q;
    tb_wdata = '0;
    tb_raddr = idx_q;
    in_stall_o = (state_q != hws_pkg::ST_IDLE);
    r = '0;
    ce = '0;
    pe = per_q;
    sl = LW'(sl_q);
    x = W'(signed'(wb_rd_q));
    xa = ACC_W'(signed'(wb_rd_q));
    pc = 1'b0;
    pcl = pred_q;
    pp = per_q * per_q;
    case (state_q)
      hws_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          clamp_d = 1'b0;
          ce = cnt_q;
          if (restart_i) begin
            ce = '0;
            lvl_d = '0;
            trd_d = '0;
            phase_d = '0;
          end
          if (ce == '0) begin
            if (sl < LW'(2)) begin
              pe = PER_W'(2);
            end else if (sl > LW'(MAX_SEASON)) begin
              pe = PER_W'(MAX_SEASON);
            end else begin
              pe = PER_W'(sl);
            end
            per_d = pe;
          end
          if (ce < {pe, 1'b0}) begin
            wb_we = 1'b1;
            wb_waddr = WA_W'(ce);
            cnt_d = ce + 1'b1;
            if (ce + 1'b1 == {pe, 1'b0}) begin
              j_d = '0;
              rpend_d = 1'b0;
              sum_d = '0;
              dif_d = '0;
              state_d = hws_pkg::ST_SUM;
            end
          end else begin
            y_d = W'(sample_i);
            replay_d = 1'b0;
            idx_d = phase_q;
            state_d = hws_pkg::ST_P_RD;
          end
        end
      end
      hws_pkg::ST_SUM: begin
        wb_raddr = WA_W'(j_q);
        if (j_q < two_per) begin
          rpend_d = 1'b1;
          rhi_d = (j_q >= CNT_W'(per_q));
          j_d = j_q + 1'b1;
        end else begin
          rpend_d = 1'b0;
        end
        if (rpend_q) begin
          if (rhi_q) begin
            dif_d = dif_q + xa;
          end else begin
            sum_d = sum_q + xa;
            dif_d = dif_q - xa;
          end
        end
        if (j_q >= two_per && !rpend_q) begin
          state_d = hws_pkg::ST_LVL;
        end
      end
      hws_pkg::ST_LVL: begin
        ua = DW'(sum_q);
        ub = DW'({per_q, {hws_pkg::FRAC_W{1'b0}}});
        req.op = hws_pkg::OP_DIV;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          lvl_d = res;
          state_d = hws_pkg::ST_TRD;
        end
      end
      hws_pkg::ST_TRD: begin
        ua = DW'(dif_q);
        ub = DW'({pp, {hws_pkg::FRAC_W{1'b0}}});
        req.op = hws_pkg::OP_DIV;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          trd_d = res;
          idx_d = '0;
          state_d = hws_pkg::ST_SEA_RD;
        end
      end
      hws_pkg::ST_SEA_RD: begin
        wb_raddr = WA_W'(idx_q);
        state_d = hws_pkg::ST_SEA_DAT;
      end
      hws_pkg::ST_SEA_DAT: begin
        if (mm_q && !lvl_q[W-1] && lvl_q != '0) begin
          y_d = x;
          state_d = hws_pkg::ST_SEA_DIV;
        end else begin
          tb_we = 1'b1;
          if (mm_q) begin
            tb_wdata = ONE_S;
          end else begin
            r = sat_add(x, lvl_q, 1'b1);
            clamp_d = clamp_d | r[W];
            tb_wdata = r[W-1:0];
          end
          if (idx_q == last_idx) begin
            idx_d = '0;
            replay_d = 1'b1;
            state_d = hws_pkg::ST_P_RD;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = hws_pkg::ST_SEA_RD;
          end
        end
      end
      hws_pkg::ST_SEA_DIV: begin
        ua = DW'(y_q);
        ub = DW'(lvl_q);
        req.op = hws_pkg::OP_DIV;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          tb_we = 1'b1;
          tb_wdata = res;
          if (idx_q == last_idx) begin
            idx_d = '0;
            replay_d = 1'b1;
            state_d = hws_pkg::ST_P_RD;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = hws_pkg::ST_SEA_RD;
          end
        end
      end
      hws_pkg::ST_P_RD: begin
        wb_raddr = WA_W'(per_q) + WA_W'(idx_q);
        state_d = hws_pkg::ST_P_DAT;
      end
      hws_pkg::ST_P_DAT: begin
        s_d = tb_rd_q;
        if (replay_q) begin
          y_d = x;
        end
        state_d = hws_pkg::ST_P_DT;
      end
      hws_pkg::ST_P_DT: begin
        ua = DW'(gd);
        ub = DW'(trd_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          dt_d = res;
          state_d = hws_pkg::ST_P_BASE;
        end
      end
      hws_pkg::ST_P_BASE: begin
        r = sat_add(lvl_q, dt_q, 1'b0);
        clamp_d = clamp_d | r[W];
        base_d = r[W-1:0];
        state_d = hws_pkg::ST_P_PRED;
      end
      hws_pkg::ST_P_PRED: begin
        if (mm_q) begin
          ua = DW'(base_q);
          ub = DW'(s_q);
          req.op = hws_pkg::OP_MUL;
          if (!run_q) begin
            req.start = 1'b1;
            run_d = 1'b1;
          end else if (rsp.done) begin
            run_d = 1'b0;
            clamp_d = clamp_d | rsp.clamp;
            pred_d = res;
            state_d = hws_pkg::ST_P_U;
          end
        end else begin
          r = sat_add(base_q, s_q, 1'b0);
          clamp_d = clamp_d | r[W];
          pred_d = r[W-1:0];
          state_d = hws_pkg::ST_P_U;
        end
      end
      hws_pkg::ST_P_U: begin
        if (mm_q) begin
          ua = DW'(y_q);
          ub = DW'(s_q);
          req.op = hws_pkg::OP_DIV;
          if (!run_q) begin
            req.start = 1'b1;
            run_d = 1'b1;
          end else if (rsp.done) begin
            run_d = 1'b0;
            clamp_d = clamp_d | rsp.clamp;
            u_d = res;
            state_d = hws_pkg::ST_P_V1;
          end
        end else begin
          r = sat_add(y_q, s_q, 1'b1);
          clamp_d = clamp_d | r[W];
          u_d = r[W-1:0];
          state_d = hws_pkg::ST_P_V1;
        end
      end
      hws_pkg::ST_P_V1: begin
        ua = DW'(ga);
        ub = DW'(u_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          v_d = res;
          state_d = hws_pkg::ST_P_V2;
        end
      end
      hws_pkg::ST_P_V2: begin
        ua = DW'(hws_pkg::GAIN_ONE - ga);
        ub = DW'(base_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          r = sat_add(v_q, res, 1'b0);
          clamp_d = clamp_d | rsp.clamp | r[W];
          nl_d = r[W-1:0];
          state_d = hws_pkg::ST_P_W;
        end
      end
      hws_pkg::ST_P_W: begin
        if (mm_q) begin
          ua = DW'(y_q);
          ub = DW'(base_q);
          req.op = hws_pkg::OP_DIV;
          if (!run_q) begin
            req.start = 1'b1;
            run_d = 1'b1;
          end else if (rsp.done) begin
            run_d = 1'b0;
            clamp_d = clamp_d | rsp.clamp;
            u_d = res;
            state_d = hws_pkg::ST_P_W1;
          end
        end else begin
          r = sat_add(y_q, base_q, 1'b1);
          clamp_d = clamp_d | r[W];
          u_d = r[W-1:0];
          state_d = hws_pkg::ST_P_W1;
        end
      end
      hws_pkg::ST_P_W1: begin
        ua = DW'(gg);
        ub = DW'(u_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          v_d = res;
          state_d = hws_pkg::ST_P_W2;
        end
      end
      hws_pkg::ST_P_W2: begin
        ua = DW'(hws_pkg::GAIN_ONE - gg);
        ub = DW'(s_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          r = sat_add(v_q, res, 1'b0);
          clamp_d = clamp_d | rsp.clamp | r[W];
          tb_we = 1'b1;
          tb_wdata = r[W-1:0];
          state_d = hws_pkg::ST_P_X1;
        end
      end
      hws_pkg::ST_P_X1: begin
        r = sat_add(nl_q, lvl_q, 1'b1);
        ua = DW'(gb);
        ub = DW'(signed'(r[W-1:0]));
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
          clamp_d = clamp_d | r[W];
        end else if (rsp.done) begin
          run_d = 1'b0;
          clamp_d = clamp_d | rsp.clamp;
          v_d = res;
          state_d = hws_pkg::ST_P_X2;
        end
      end
      hws_pkg::ST_P_X2: begin
        ua = DW'(hws_pkg::GAIN_ONE - gb);
        ub = DW'(dt_q);
        req.op = hws_pkg::OP_MUL;
        if (!run_q) begin
          req.start = 1'b1;
          run_d = 1'b1;
        end else if (rsp.done) begin
          run_d = 1'b0;
          r = sat_add(v_q, res, 1'b0);
          clamp_d = clamp_d | rsp.clamp | r[W];
          trd_d = r[W-1:0];
          lvl_d = nl_q;
          state_d = hws_pkg::ST_P_EMIT;
        end
      end
      hws_pkg::ST_P_EMIT: begin
        if (pred_q > PMAX) begin
          pcl = PMAX;
          pc = 1'b1;
        end else if (pred_q < PMIN) begin
          pcl = PMIN;
          pc = 1'b1;
        end
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          opred_d = pcl[hws_pkg::SAMPLE_W-1:0];
          oerr_d = hws_pkg::ERR_W'(signed'(y_q[hws_pkg::SAMPLE_W-1:0]))
                 - hws_pkg::ERR_W'(signed'(pcl[hws_pkg::SAMPLE_W-1:0]));
          osat_d = clamp_q | pc;
          olast_d = !replay_q || (idx_q == last_idx);
          clamp_d = 1'b0;
          if (replay_q && idx_q != last_idx) begin
            idx_d = idx_q + 1'b1;
            state_d = hws_pkg::ST_P_RD;
          end else begin
            if (replay_q) begin
              phase_d = '0;
            end else if (PER_W'(phase_q) + 1'b1 >= per_q) begin
              phase_d = '0;
            end else begin
              phase_d = phase_q + 1'b1;
            end
            state_d = hws_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = hws_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o        = ov_q;
  assign prediction_o       = opred_q;
  assign prediction_error_o = oerr_q;
  assign last_of_run_o      = olast_q;
  assign saturated_o        = osat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    per_q >= PER_W'(2) && per_q <= PER_W'(MAX_SEASON))
    else $error("Period in use is out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= two_per)
    else $error("Warm-up count passed two seasons.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> run_q)
    else $error("Arithmetic result arrived with no operation pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hws_pkg::ST_P_EMIT && (!ov_q || !out_stall_i) |=> out_valid_o)
    else $error("Result was loaded but not presented.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q && state_q != hws_pkg::ST_IDLE |-> idx_q <= last_idx)
    else $error("Replay index passed the period.");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam longint STATE_MAX  = (64'sd1 <<< 39) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint Q_ONE      = 65536;
  localparam int     RAND_ITEMS = 20;
  localparam int     CYCLE_CAP  = 1000000;
  localparam int     DRAIN      = 400;

  typedef struct {
    logic [hws_pkg::SAMPLE_W-1:0] pred;
    logic [hws_pkg::ERR_W-1:0]    err;
    logic                         last;
    logic                         sat;
  } forecast_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [hws_pkg::SAMPLE_W-1:0] sample_i;
  logic                                restart_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [hws_pkg::SAMPLE_W-1:0] prediction_o;
  logic signed [hws_pkg::ERR_W-1:0]    prediction_error_o;
  logic                                last_of_run_o;
  logic                                saturated_o;
  logic                                cfg_we_i;
  logic [hws_pkg::CFG_IDX_W-1:0]       cfg_idx_i;
  logic [hws_pkg::GAIN_W-1:0]          cfg_wdata_i;

  holt_winters_seasonal_predictor u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .prediction_o       (prediction_o),
    .prediction_error_o (prediction_error_o),
    .last_of_run_o      (last_of_run_o),
    .saturated_o        (saturated_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Shadow registers and forecaster state.
  int unsigned alpha_reg, beta_reg, gamma_reg, phi_reg, damp_on, mult_on, period_reg;
  longint      warm_buf [2*64];
  longint      season_tab [64];
  longint      level_st, trend_st;
  int unsigned seen_cnt, phase_cnt, period_cur;
  bit          clamp_seen;

  forecast_t   forecast_q [$];
  int          error_cnt;
  int          cycle_cnt;
  int          rand_items;
  bit          gaps_on;
  bit          result_xfer;
  int          hold_left;
  int          stall_left;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [127:0] mag128(longint x);
    return x < 0 ? 128'(-x) : 128'(x);
  endfunction

  function automatic longint from_mag(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'(STATE_MAX) + 1) begin
        clamp_seen = 1'b1;
        return STATE_MIN;
      end
      return -longint'(m[63:0]);
    end
    if (m > 128'(STATE_MAX)) begin
      clamp_seen = 1'b1;
      return STATE_MAX;
    end
    return longint'(m[63:0]);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > STATE_MAX) begin
      clamp_seen = 1'b1;
      return STATE_MAX;
    end
    if (s < STATE_MIN) begin
      clamp_seen = 1'b1;
      return STATE_MIN;
    end
    return s;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = mag128(a) * mag128(b) + 128'h8000;
    return from_mag((a < 0) != (b < 0), p >> 16);
  endfunction

  function automatic longint q_div(longint a, longint b);
    logic [127:0] n, d, q, r;
    if (b == 0) begin
      clamp_seen = 1'b1;
      return a > 0 ? STATE_MAX : (a < 0 ? STATE_MIN : 0);
    end
    n = mag128(a) << 16;
    d = mag128(b);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return from_mag((a < 0) != (b < 0), q);
  endfunction

  function automatic longint clip_gain(int unsigned g);
    return g > Q_ONE ? Q_ONE : longint'(g);
  endfunction

  function automatic void forecast_step(longint y, int unsigned k, bit last);
    longint a, b, g, d, s, prev, dt, base, pred, lvl;
    forecast_t f;
    a = clip_gain(alpha_reg);
    b = clip_gain(beta_reg);
    g = clip_gain(gamma_reg);
    d = damp_on ? clip_gain(phi_reg) : Q_ONE;
    s = season_tab[k];
    prev = level_st;
    dt = q_mul(d, trend_st);
    base = sat_add(prev, dt);
    if (mult_on) begin
      pred = q_mul(base, s);
      lvl = sat_add(q_mul(a, q_div(y, s)), q_mul(Q_ONE - a, base));
      season_tab[k] = sat_add(q_mul(g, q_div(y, base)), q_mul(Q_ONE - g, s));
    end else begin
      pred = sat_add(base, s);
      lvl = sat_add(q_mul(a, sat_add(y, -s)), q_mul(Q_ONE - a, base));
      season_tab[k] = sat_add(q_mul(g, sat_add(y, -base)), q_mul(Q_ONE - g, s));
    end
    trend_st = sat_add(q_mul(b, sat_add(lvl, -prev)), q_mul(Q_ONE - b, dt));
    level_st = lvl;
    if (pred > 64'sd2147483647) begin
      pred = 64'sd2147483647;
      clamp_seen = 1'b1;
    end
    if (pred < -64'sd2147483648) begin
      pred = -64'sd2147483648;
      clamp_seen = 1'b1;
    end
    f.pred = pred[hws_pkg::SAMPLE_W-1:0];
    f.err  = hws_pkg::ERR_W'(y - pred);
    f.last = last;
    f.sat  = clamp_seen;
    forecast_q = {forecast_q, f};
    clamp_seen = 1'b0;
  endfunction

  function automatic void seed_state(int unsigned p);
    longint sum, diff;
    sum = 0;
    diff = 0;
    for (int unsigned i = 0; i < p; i++) begin
      sum += warm_buf[i];
      diff += warm_buf[p+i] - warm_buf[i];
    end
    level_st = q_div(sum, longint'(p) * Q_ONE);
    trend_st = q_div(diff, longint'(p) * longint'(p) * Q_ONE);
    for (int unsigned i = 0; i < p; i++) begin
      if (mult_on) season_tab[i] = level_st > 0 ? q_div(warm_buf[i], level_st) : Q_ONE;
      else season_tab[i] = sat_add(warm_buf[i], -level_st);
    end
  endfunction

  function automatic void forecast_accept(logic signed [31:0] smp, bit rst);
    longint y;
    int unsigned p;
    y = smp;
    clamp_seen = 1'b0;
    if (rst) begin
      level_st = 0;
      trend_st = 0;
      seen_cnt = 0;
      phase_cnt = 0;
    end
    if (seen_cnt == 0) begin
      p = period_reg;
      if (p < 2) p = 2;
      if (p > 64) p = 64;
      period_cur = p;
    end
    p = period_cur;
    if (seen_cnt < 2*p) begin
      warm_buf[seen_cnt] = y;
      seen_cnt++;
      if (seen_cnt < 2*p) return;
      seed_state(p);
      for (int unsigned t = 0; t < p; t++) forecast_step(warm_buf[p+t], t, t == p-1);
      phase_cnt = 0;
      return;
    end
    forecast_step(y, phase_cnt, 1'b1);
    phase_cnt = (phase_cnt + 1 >= p) ? 0 : phase_cnt + 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
    error_cnt++;
  endtask

  // Result checker: a transfer happens at the next rising edge when valid and not stalled.
  always @(negedge clk_i) begin
    forecast_t f;
    result_xfer = out_valid_o && !out_stall_i;
    if (result_xfer) begin
      if (forecast_q.size() == 0) begin
        report_mismatch("unexpected result", 0, prediction_o);
      end else begin
        f = forecast_q.pop_front();
        if (prediction_o !== f.pred) report_mismatch("prediction", f.pred, prediction_o);
        if (prediction_error_o !== f.err) report_mismatch("error", f.err, prediction_error_o);
        if (last_of_run_o !== f.last) report_mismatch("last_of_run", f.last, last_of_run_o);
        if (saturated_o !== f.sat) report_mismatch("saturated", f.sat, saturated_o);
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (result_xfer && gaps_on && $urandom_range(0, 2) != 0)
        stall_left <= $urandom_range(0, 18);
    end
  end

  task automatic send_sample(logic signed [31:0] smp, bit rst);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    restart_i  <= rst;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    forecast_accept(smp, rst);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (forecast_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(hws_pkg::hws_cfg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[hws_pkg::GAIN_W-1:0];
    case (idx)
      hws_pkg::CFG_LEVEL_GAIN:     alpha_reg = val & 32'h1FFFF;
      hws_pkg::CFG_TREND_GAIN:     beta_reg = val & 32'h1FFFF;
      hws_pkg::CFG_SEASON_GAIN:    gamma_reg = val & 32'h1FFFF;
      hws_pkg::CFG_DAMPING_FACTOR: phi_reg = val & 32'h1FFFF;
      hws_pkg::CFG_DAMPING_ENABLE: damp_on = val & 1;
      hws_pkg::CFG_MULT_MODE:      mult_on = val & 1;
      hws_pkg::CFG_SEASON_LENGTH:  period_reg = val & 32'h7F;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(int unsigned a, int unsigned b, int unsigned g, int unsigned phi,
                           int unsigned de, int unsigned mm, int unsigned len);
    write_reg(hws_pkg::CFG_LEVEL_GAIN, a);
    write_reg(hws_pkg::CFG_TREND_GAIN, b);
    write_reg(hws_pkg::CFG_SEASON_GAIN, g);
    write_reg(hws_pkg::CFG_DAMPING_FACTOR, phi);
    write_reg(hws_pkg::CFG_DAMPING_ENABLE, de);
    write_reg(hws_pkg::CFG_MULT_MODE, mm);
    write_reg(hws_pkg::CFG_SEASON_LENGTH, len);
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_sample(int kind, int unsigned idx, int unsigned p);
    case (kind)
      0: return $urandom;
      1: return ((32'(idx % p) * 5 + 40) << 16) + $urandom_range(0, 131071);
      2: return -((32'(idx % p) * 3 + 2) << 16) + $urandom_range(0, 65535);
      default: return 32'(idx) * 32'h1_0000 + $urandom_range(0, 32767) - 16384;
    endcase
  endfunction

  task automatic test_directed_additive();
    write_all(131071, 0, 65536, 0, 1, 0, 0);
    send_sample(32'sh7FFFFFFF, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    wait_idle();
  endtask

  task automatic test_directed_multiplicative();
    write_all(65536, 65536, 0, 65536, 0, 1, 1);
    // Negative level: every season entry falls back to one.
    send_sample(-32'sd5 <<< 16, 1'b1);
    send_sample(-32'sd3 <<< 16, 1'b0);
    send_sample(32'sd1 <<< 16, 1'b0);
    send_sample(32'sd2 <<< 16, 1'b0);
    send_sample(32'sd3 <<< 16, 1'b0);
    // A zero sample in season one gives a zero season entry, so the next division is by zero.
    send_sample(32'sd0, 1'b1);
    send_sample(32'sd4 <<< 16, 1'b0);
    send_sample(32'sd2 <<< 16, 1'b0);
    send_sample(32'sd6 <<< 16, 1'b0);
    send_sample(32'sd1 <<< 16, 1'b0);
    send_sample(32'sd0, 1'b0);
    // A restart in the middle of the warm-up.
    send_sample(32'sd1 <<< 16, 1'b1);
    send_sample(32'sd2 <<< 16, 1'b1);
    wait_idle();
  endtask

  task automatic test_period_limits();
    write_all(19661, 6554, 6554, 64225, 0, 0, 127);
    for (int i = 0; i < 130; i++) send_sample(pick_sample(3, i, 64), i == 0);
    wait_idle();
    // The new period must wait for the next restart.
    write_reg(hws_pkg::CFG_SEASON_LENGTH, 3);
    for (int i = 0; i < 3; i++) send_sample(pick_sample(0, i, 3), 1'b0);
    for (int i = 0; i < 7; i++) send_sample(pick_sample(1, i, 3), i == 0);
    wait_idle();
  endtask

  task automatic test_random_runs();
    int unsigned len, p, n;
    int kind;
    while (rand_items < RAND_ITEMS) begin
      gaps_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0: len = $urandom_range(0, 1);
        1: len = 12;
        2: len = $urandom_range(65, 127);
        default: len = $urandom_range(2, 5);
      endcase
      write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                $urandom_range(0, 1), $urandom_range(0, 1), len);
      p = len < 2 ? 2 : (len > 64 ? 64 : len);
      if (p > 12) p = 2;
      if (len > 12) write_reg(hws_pkg::CFG_SEASON_LENGTH, 2);
      kind = $urandom_range(0, 3);
      n = 2*p + $urandom_range(0, 12);
      for (int unsigned i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 39) == 0) begin
          send_sample($urandom, 1'b1);
          i = 0;
        end else begin
          send_sample(pick_sample(kind, i, p), i == 0);
        end
        rand_items++;
      end
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    write_all(30000, 20000, 10000, 60000, 1, 0, 2);
    @(negedge clk_i);
    hold_left = 1500;
    @(posedge clk_i);
    for (int i = 0; i < 30; i++) send_sample(pick_sample(3, i, 2), i == 0);
    wait_idle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    restart_i   = 1'b0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    error_cnt   = 0;
    cycle_cnt   = 0;
    rand_items  = 0;
    hold_left   = 0;
    stall_left  = 0;
    gaps_on     = 1'b1;
    alpha_reg   = 19661;
    beta_reg    = 6554;
    gamma_reg   = 6554;
    phi_reg     = 64225;
    damp_on     = 0;
    mult_on     = 0;
    period_reg  = 12;
    period_cur  = 12;
    level_st    = 0;
    trend_st    = 0;
    seen_cnt    = 0;
    phase_cnt   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_additive();
    test_directed_multiplicative();
    test_period_limits();
    test_output_backpressure();
    gaps_on = 1'b1;
    test_random_runs();

    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/hws_pkg.sv
design/hws_arith.sv
design/holt_winters_seasonal_predictor.sv
verif/tb.sv
